[src/idrd_pkg.sv]
// Package of the IPFIX data record delineator: item, result and configuration types,
// result and status codes, and constants shared by all modules of the block.
// Depends on nothing; every other file but idrd_if refers to it by scoped names.
package idrd_pkg;

	localparam int MAX_FIELDS_DEF = 64;
	localparam int RES_FIFO_DEPTH = 4;

	localparam logic [15:0] VAR_MARK = 16'hFFFF;
	localparam logic [7:0] ESC_BYTE = 8'hFF;
	localparam logic [15:0] SAT_MAX = 16'hFFFF;
	localparam logic [15:0] HDR_LEN_HI_POS = 16'd2;
	localparam logic [15:0] HDR_LEN_LO_POS = 16'd3;
	localparam logic [15:0] HDR_BYTES = 16'd4;
	localparam logic [14:0] MIN_LEN_RESET = 15'd1;

	localparam logic [1:0] CFG_FIELD_COUNT = 2'd0;
	localparam logic [1:0] CFG_MIN_LENGTH = 2'd1;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_BYTE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_LOAD_ACK = 2'd0,
		KIND_RECORD   = 2'd1,
		KIND_SET_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_TRUNCATED    = 2'd1,
		ST_MISMATCH     = 2'd2,
		ST_BAD_TEMPLATE = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [5:0]  field_index;
		logic [15:0] field_length;
		logic [7:0]  set_byte;
		logic        set_last;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] record_offset;
		logic [15:0] record_length;
		logic [15:0] record_count;
		status_t     status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [6:0]  field_count;
		logic [14:0] min_record_length;
	} cfg_t;

	// Address width of the template table for a given number of slots.
	function automatic int addr_width(int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

[src/idrd_if.sv]
// Channel interfaces of the IPFIX data record delineator: input items, result items
// and configuration writes, each with valid, ready and its payload signals.
// Depends on nothing.
interface idrd_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [5:0]  field_index;
	logic [15:0] field_length;
	logic [7:0]  set_byte;
	logic        set_last;

	modport source (output valid, cmd, field_index, field_length, set_byte, set_last,
		input ready);
	modport sink (input valid, cmd, field_index, field_length, set_byte, set_last,
		output ready);
endinterface

interface idrd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] record_offset;
	logic [15:0] record_length;
	logic [15:0] record_count;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, kind, record_offset, record_length, record_count,
		status, last, input ready);
	modport sink (input valid, kind, record_offset, record_length, record_count,
		status, last, output ready);
endinterface

interface idrd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[src/idrd_tmpl_mem.sv]
// Template field length table: one write port and two registered read ports.
// A write and a read of the same slot at one edge forward the new value.
// Depends on idrd_pkg.
module idrd_tmpl_mem #(
	parameter int DEPTH = idrd_pkg::MAX_FIELDS_DEF
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [idrd_pkg::addr_width(DEPTH)-1:0] waddr,
	input  logic [15:0]                            wdata,
	input  logic [idrd_pkg::addr_width(DEPTH)-1:0] raddr_a,
	input  logic [idrd_pkg::addr_width(DEPTH)-1:0] raddr_b,
	output logic [15:0]                            rdata_a,
	output logic [15:0]                            rdata_b
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
		rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
	end

endmodule

[src/idrd_result_fifo.sv]
// Result queue of the delineator: takes up to two result items per cycle and
// hands out one per handshake. Depends on idrd_pkg.
module idrd_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  idrd_pkg::result_t push0,
	input  idrd_pkg::result_t push1,
	output logic              has_room,
	output logic              out_valid,
	input  logic              out_ready,
	output idrd_pkg::result_t out_data
);

	localparam int DEPTH = idrd_pkg::RES_FIFO_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	idrd_pkg::result_t entry_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic pop;

	// Room for the two results that one set byte may cause.
	assign has_room = (32'(cnt_q) <= DEPTH - 2);
	assign out_valid = (cnt_q != '0);
	assign out_data = entry_q[rp_q];
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entry_q[wp_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			entry_q[wp_q + PW'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + PW'(push_cnt);
			rp_q <= rp_q + PW'(pop);
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) + 32'(push_cnt) <= DEPTH + 32'(pop)))
		else $error("result queue overflow");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd2) |-> (32'(cnt_q) <= DEPTH - 2))
		else $error("two results pushed without room");
`endif

endmodule

[src/idrd_parser.sv]
// Set parser of the delineator: holds the per-set state, walks the template one
// byte per cycle when not stalled, against the table read issued the cycle before,
// and forms results. Depends on idrd_pkg; drives the ports of idrd_tmpl_mem.
module idrd_parser #(
	parameter int MAX_FIELDS = idrd_pkg::MAX_FIELDS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_accept,
	input  idrd_pkg::item_t                             item,
	input  idrd_pkg::cfg_t                              cfg,
	input  logic [15:0]                                 tmpl_a,
	input  logic [15:0]                                 tmpl_b,
	output logic                                        tmpl_we,
	output logic [idrd_pkg::addr_width(MAX_FIELDS)-1:0] tmpl_waddr,
	output logic [15:0]                                 tmpl_wdata,
	output logic [idrd_pkg::addr_width(MAX_FIELDS)-1:0] tmpl_raddr_a,
	output logic [idrd_pkg::addr_width(MAX_FIELDS)-1:0] tmpl_raddr_b,
	output logic [1:0]                                  res_cnt,
	output idrd_pkg::result_t                           res0,
	output idrd_pkg::result_t                           res1
);

	localparam int AW = idrd_pkg::addr_width(MAX_FIELDS);

	typedef enum logic [7:0] {
		PH_HEADER = 8'b0000_0001,
		PH_GAP    = 8'b0000_0010,
		PH_FIXED  = 8'b0000_0100,
		PH_VARLEN = 8'b0000_1000,
		PH_ESC_HI = 8'b0001_0000,
		PH_ESC_LO = 8'b0010_0000,
		PH_PAD    = 8'b0100_0000,
		PH_BAD    = 8'b1000_0000
	} phase_t;

	phase_t ph_q, ph_d;
	logic [6:0]  cf_q, cf_d;
	logic [15:0] br_q, br_d;
	logic [7:0]  esc_q, esc_d;
	logic [15:0] slen_q, slen_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] rst_q, rst_d;
	logic [15:0] rseen_q, rseen_d;

	logic [6:0]  active;
	logic [16:0] gap_need;
	logic [15:0] esc_len;
	logic [15:0] next_len;
	logic [7:0]  next_idx;
	logic        started;
	logic        fdone;
	logic        rec_done;
	idrd_pkg::result_t summary;

	function automatic phase_t enter_phase(logic [15:0] len);
		if (len == idrd_pkg::VAR_MARK) begin
			return PH_VARLEN;
		end else if (len == 16'd0) begin
			return PH_BAD;
		end
		return PH_FIXED;
	endfunction

	assign active = (32'(cfg.field_count) > MAX_FIELDS) ? 7'(MAX_FIELDS) : cfg.field_count;
	assign gap_need = {1'b0, pos_q} + {2'b0, cfg.min_record_length};
	assign esc_len = {esc_q, item.set_byte};
	// The second field of a record, entered on its first byte, comes from port B.
	assign next_len = started ? tmpl_b : tmpl_a;

	assign tmpl_we = in_accept && (item.cmd == idrd_pkg::CMD_LOAD) &&
		(32'(item.field_index) < MAX_FIELDS);
	assign tmpl_waddr = AW'(item.field_index);
	assign tmpl_wdata = item.field_length;

	always_comb begin
		ph_d = ph_q;
		cf_d = cf_q;
		br_d = br_q;
		esc_d = esc_q;
		slen_d = slen_q;
		pos_d = pos_q;
		rst_d = rst_q;
		rseen_d = rseen_q;
		started = 1'b0;
		fdone = 1'b0;
		rec_done = 1'b0;
		res_cnt = 2'd0;
		res0 = '0;
		res1 = '0;
		summary = '0;
		if (in_accept) begin
			if (item.cmd == idrd_pkg::CMD_LOAD) begin
				res_cnt = 2'd1;
				res0.kind = idrd_pkg::KIND_LOAD_ACK;
				res0.last = 1'b1;
			end else begin
				if (ph_q == PH_HEADER) begin
					if (pos_q == idrd_pkg::HDR_LEN_HI_POS) begin
						slen_d = {item.set_byte, 8'h00};
					end else if (pos_q == idrd_pkg::HDR_LEN_LO_POS) begin
						slen_d = {slen_q[15:8], item.set_byte};
						ph_d = PH_GAP;
					end
				end else begin
					if (ph_q == PH_GAP) begin
						if ({1'b0, slen_q} >= gap_need) begin
							if (rseen_q != idrd_pkg::SAT_MAX) begin
								rseen_d = rseen_q + 16'd1;
							end
							rst_d = pos_q;
							cf_d = '0;
							started = 1'b1;
							if (active == '0) begin
								ph_d = PH_BAD;
							end else begin
								ph_d = enter_phase(tmpl_a);
								if (ph_d == PH_FIXED) begin
									br_d = tmpl_a;
								end
							end
						end else begin
							ph_d = PH_PAD;
						end
					end
					unique case (ph_d)
						PH_FIXED: begin
							br_d = br_d - 16'd1;
							fdone = (br_d == 16'd0);
						end
						PH_VARLEN: begin
							if (item.set_byte == idrd_pkg::ESC_BYTE) begin
								ph_d = PH_ESC_HI;
							end else if (item.set_byte == 8'd0) begin
								fdone = 1'b1;
							end else begin
								br_d = {8'h00, item.set_byte};
								ph_d = PH_FIXED;
							end
						end
						PH_ESC_HI: begin
							esc_d = item.set_byte;
							ph_d = PH_ESC_LO;
						end
						PH_ESC_LO: begin
							if (esc_len == 16'd0) begin
								fdone = 1'b1;
							end else begin
								br_d = esc_len;
								ph_d = PH_FIXED;
							end
						end
						default: begin
						end
					endcase
					if (fdone) begin
						cf_d = cf_d + 7'd1;
						if (cf_d >= active) begin
							ph_d = PH_GAP;
							rec_done = 1'b1;
						end else begin
							ph_d = enter_phase(next_len);
							if (ph_d == PH_FIXED) begin
								br_d = next_len;
							end
						end
					end
				end

				if (rec_done) begin
					res_cnt = 2'd1;
					res0.kind = idrd_pkg::KIND_RECORD;
					res0.record_offset = rst_d;
					res0.record_length = pos_q + 16'd1 - rst_d;
					res0.record_count = rseen_d;
					res0.status = idrd_pkg::ST_OK;
					res0.last = !item.set_last;
				end

				if (item.set_last) begin
					summary.kind = idrd_pkg::KIND_SET_DONE;
					summary.record_count = rseen_d;
					summary.last = 1'b1;
					priority if (ph_d == PH_BAD) begin
						summary.status = idrd_pkg::ST_BAD_TEMPLATE;
					end else if (ph_d == PH_HEADER) begin
						summary.status = idrd_pkg::ST_MISMATCH;
					end else if ((ph_d == PH_FIXED) || (ph_d == PH_VARLEN) ||
						(ph_d == PH_ESC_HI) || (ph_d == PH_ESC_LO)) begin
						summary.status = idrd_pkg::ST_TRUNCATED;
					end else if (({1'b0, pos_q} + 17'd1) != {1'b0, slen_d}) begin
						summary.status = idrd_pkg::ST_MISMATCH;
					end else begin
						summary.status = idrd_pkg::ST_OK;
					end
					if (rec_done) begin
						res1 = summary;
						res_cnt = 2'd2;
					end else begin
						res0 = summary;
						res_cnt = 2'd1;
					end
					ph_d = PH_HEADER;
					cf_d = '0;
					br_d = '0;
					esc_d = '0;
					slen_d = '0;
					pos_d = '0;
					rst_d = '0;
					rseen_d = '0;
				end else if (pos_q != idrd_pkg::SAT_MAX) begin
					pos_d = pos_q + 16'd1;
				end
			end
		end
	end

	// Read for the next byte: slot 0 (and slot 1 on port B) while between records,
	// otherwise the slot after the current field.
	always_comb begin
		next_idx = {1'b0, cf_d} + 8'd1;
		if (ph_d == PH_GAP) begin
			tmpl_raddr_a = '0;
		end else if (32'(next_idx) < MAX_FIELDS) begin
			tmpl_raddr_a = AW'(next_idx);
		end else begin
			tmpl_raddr_a = '0;
		end
	end

	assign tmpl_raddr_b = (MAX_FIELDS > 1) ? AW'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HEADER;
			cf_q <= '0;
			br_q <= '0;
			esc_q <= '0;
			slen_q <= '0;
			pos_q <= '0;
			rst_q <= '0;
			rseen_q <= '0;
		end else begin
			ph_q <= ph_d;
			cf_q <= cf_d;
			br_q <= br_d;
			esc_q <= esc_d;
			slen_q <= slen_d;
			pos_q <= pos_d;
			rst_q <= rst_d;
			rseen_q <= rseen_d;
		end
	end

`ifndef ASSERT_OFF
	a_fixed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_FIXED) |-> (br_q != 16'd0))
		else $error("fixed field with no bytes remaining");
	a_header_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != PH_HEADER) |-> (pos_q >= idrd_pkg::HDR_BYTES))
		else $error("parsing records inside the set header");
	a_set_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (item.cmd == idrd_pkg::CMD_BYTE) && item.set_last) |=>
		((ph_q == PH_HEADER) && (pos_q == 16'd0) && (rseen_q == 16'd0)))
		else $error("set state not cleared after last byte");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res_cnt == 2'd2) |-> ((res0.kind == idrd_pkg::KIND_RECORD) &&
		(res1.kind == idrd_pkg::KIND_SET_DONE) && !res0.last))
		else $error("result pair out of order");
`endif

endmodule

[src/ipfix_data_record_delineator_top.sv]
// Top level of the IPFIX data record delineator: configuration registers and the
// connection of parser, template table and result queue. Depends on idrd_pkg, idrd_if,
// idrd_tmpl_mem, idrd_parser and idrd_result_fifo.
//
// Usage: the items channel carries load items (cmd 0), which write one template field
// length into the table, and set items (cmd 1), one byte of an IPFIX data set each,
// header first, with set_last on the final byte. Every load item yields one
// acknowledge; a set byte yields a record result when it closes a record and a set
// summary when it is the last byte, so one item causes zero, one or two results.
// The cfg channel writes field_count (index 0) and min_record_length (index 1); it is
// always ready; the user must write it only while no item is in flight, which the
// block does not enforce. Throughput is one item per cycle while the result queue
// has room: the template table is read in the cycle before the byte that needs it,
// with the address taken from the parser state after the previous byte, so no item
// waits for its table read; its results are registered in the queue before the output.
// Results wait in a four-entry queue; while the receiver stalls the block keeps taking
// items until fewer than two queue slots are free, then drops ready.
// Reset clears the parse state and the configuration (field_count 0, minimum record
// length 1) at once; the template table keeps no reset and must be loaded first.
module ipfix_data_record_delineator_top #(
	parameter int MAX_FIELDS = idrd_pkg::MAX_FIELDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	idrd_item_if.sink    items,
	idrd_result_if.source results,
	idrd_cfg_if.sink     cfg
);

	localparam int AW = idrd_pkg::addr_width(MAX_FIELDS);

	idrd_pkg::cfg_t    cfg_q;
	idrd_pkg::item_t   item;
	idrd_pkg::result_t res0, res1, res_out;
	logic [1:0]        res_cnt;
	logic              in_accept;
	logic              has_room;
	logic              tmpl_we;
	logic [AW-1:0]     tmpl_waddr, tmpl_raddr_a, tmpl_raddr_b;
	logic [15:0]       tmpl_wdata, tmpl_a, tmpl_b;

	// Configuration is applied at once; writes to unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_count <= '0;
			cfg_q.min_record_length <= idrd_pkg::MIN_LEN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				idrd_pkg::CFG_FIELD_COUNT: cfg_q.field_count <= cfg.data[6:0];
				idrd_pkg::CFG_MIN_LENGTH: cfg_q.min_record_length <= cfg.data[14:0];
				default: begin
				end
			endcase
		end
	end

	// An item is taken whenever the result queue can absorb two more results.
	assign items.ready = has_room;
	assign in_accept = items.valid && has_room;

	assign item.cmd = idrd_pkg::cmd_t'(items.cmd);
	assign item.field_index = items.field_index;
	assign item.field_length = items.field_length;
	assign item.set_byte = items.set_byte;
	assign item.set_last = items.set_last;

	idrd_tmpl_mem #(
		.DEPTH(MAX_FIELDS)
	) u_tmpl_mem (
		.clk    (clk),
		.we     (tmpl_we),
		.waddr  (tmpl_waddr),
		.wdata  (tmpl_wdata),
		.raddr_a(tmpl_raddr_a),
		.raddr_b(tmpl_raddr_b),
		.rdata_a(tmpl_a),
		.rdata_b(tmpl_b)
	);

	idrd_parser #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.item        (item),
		.cfg         (cfg_q),
		.tmpl_a      (tmpl_a),
		.tmpl_b      (tmpl_b),
		.tmpl_we     (tmpl_we),
		.tmpl_waddr  (tmpl_waddr),
		.tmpl_wdata  (tmpl_wdata),
		.tmpl_raddr_a(tmpl_raddr_a),
		.tmpl_raddr_b(tmpl_raddr_b),
		.res_cnt     (res_cnt),
		.res0        (res0),
		.res1        (res1)
	);

	idrd_result_fifo u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (res_cnt),
		.push0    (res0),
		.push1    (res1),
		.has_room (has_room),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.out_data (res_out)
	);

	assign results.kind = res_out.kind;
	assign results.record_offset = res_out.record_offset;
	assign results.record_length = res_out.record_length;
	assign results.record_count = res_out.record_count;
	assign results.status = res_out.status;
	assign results.last = res_out.last;

endmodule
